[src/dq_pkg.sv]
// shared types and constants for the double-ended queue
`default_nettype none

package dq_pkg;

  // ring depth must be a power of two so that slot arithmetic wraps by truncation
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_FRONT      = 4'd4,
    OP_BACK       = 4'd5,
    OP_SIZE       = 4'd6,
    OP_CLEAR      = 4'd7,
    OP_EXIT       = 4'd8
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_VALUE = 3'd1,
    ST_EMPTY = 3'd2,
    ST_SIZE  = 3'd3,
    ST_BYE   = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data_value;
    logic [10:0]        element_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // command transfer: latch command, start store read
    logic commit;  // apply command to ring state and load the result register
  } dq_ctl_t;

endpackage

`default_nettype wire

[src/double_ended_queue_top.sv]
// top level of the double-ended queue
`default_nettype none

// Bounded double-ended queue of 1024 signed 32-bit values in a single-port-style
// ring memory. Every command transfer gives exactly one result transfer. A
// command first gets a registered memory read of the front or back slot when
// it is taken, then an update of the head and count together with the load
// of the result register; the next command is taken in the cycle after
// that update. A command may be taken while the previous result still waits
// downstream; its commit then waits until that result register frees up.
// Pushes on a full queue answer full error, pops and peeks on an empty queue
// answer empty error, and clear and exit empty the queue at once with no
// sweep of the memory.
module double_ended_queue_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  output logic              cmd_stall,
  input  wire dq_pkg::cmd_t cmd,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output dq_pkg::rsp_t      rsp
);
  import dq_pkg::*;

  dq_ctl_t ctl;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  dq_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

[src/dq_ctrl.sv]
// control state machine for the double-ended queue
`default_nettype none

module dq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output dq_pkg::dq_ctl_t     ctl
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   slot_free;

  assign cmd_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  assign ctl.load   = cmd_valid && (state == S_IDLE);
  assign ctl.commit = (state == S_EXEC) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // a new result takes the slot in the same cycle the old one transfers
      if (ctl.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // wait here until the result register can take the new result
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/dq_datapath.sv]
// ring store, head and occupancy registers and result register
`default_nettype none

module dq_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dq_pkg::dq_ctl_t ctl,
  input  wire dq_pkg::cmd_t    cmd,
  output dq_pkg::rsp_t         rsp
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] store [DEPTH];

  logic [IDX_W-1:0]      head, head_next;
  logic [CNT_W-1:0]      occ, occ_next;
  cmd_t                  cmd_reg;
  logic [DATA_WIDTH-1:0] rd_data;

  logic [IDX_W-1:0]      back_slot;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_en;
  logic                  full;
  logic                  empty;
  rsp_t                  rsp_next;

  assign full      = (occ == CNT_W'(DEPTH));
  assign empty     = (occ == '0);
  assign back_slot = head + occ[IDX_W-1:0] - IDX_W'(1);

  // read address chosen from the incoming command, state is settled by then
  always_comb begin
    if (cmd.opcode == OP_POP_FRONT || cmd.opcode == OP_FRONT) begin
      rd_addr = head;
    end else begin
      rd_addr = back_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_reg <= cmd;
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= DATA_WIDTH'(cmd_reg.push_value);
    end
  end

  always_comb begin
    head_next              = head;
    occ_next               = occ;
    wr_en                  = 1'b0;
    wr_addr                = head + occ[IDX_W-1:0];
    rsp_next.status        = ST_OK;
    rsp_next.data_value    = '0;
    unique case (cmd_reg.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          wr_en    = ctl.commit;
          occ_next = occ + CNT_W'(1);
          if (cmd_reg.opcode == OP_PUSH_FRONT) begin
            head_next = head - IDX_W'(1);
            wr_addr   = head - IDX_W'(1);
          end
        end
      end
      OP_POP_FRONT, OP_FRONT, OP_POP_BACK, OP_BACK: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.status     = ST_VALUE;
          rsp_next.data_value = 32'(signed'(rd_data));
          if (cmd_reg.opcode == OP_POP_FRONT) begin
            head_next = head + IDX_W'(1);
            occ_next  = occ - CNT_W'(1);
          end else if (cmd_reg.opcode == OP_POP_BACK) begin
            occ_next = occ - CNT_W'(1);
          end
        end
      end
      OP_SIZE: begin
        rsp_next.status = ST_SIZE;
      end
      OP_CLEAR, OP_EXIT: begin
        head_next = '0;
        occ_next  = '0;
        if (cmd_reg.opcode == OP_EXIT) begin
          rsp_next.status = ST_BYE;
        end
      end
      default: begin
        // unused opcodes leave the queue as it is
      end
    endcase
    rsp_next.element_count = 11'(occ_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (ctl.commit) begin
      head <= head_next;
      occ  <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// self-checking testbench for the double-ended queue top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 12;

  // opcodes the block ignores, still answered with ok
  localparam logic [3:0] OP_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} load_mode_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] value;
    bit          typed;
    status_t     st;
    logic [31:0] dv;
    logic [10:0] n;
  } dir_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // typed expectation travels alongside the command it belongs to
  bit   use_typed = 1'b0;
  rsp_t typed_rsp = '0;

  // queue model
  logic signed [DATA_WIDTH-1:0] ring [DEPTH];
  logic [IDX_W-1:0] ring_head = '0;
  logic [CNT_W-1:0] ring_count = '0;

  rsp_t expected_rsps[$];
  int   send_gap_pct = 0;
  int   stall_pct = 0;
  int   burst_req = 0;
  int   burst_done = 0;
  int   fail_count = 0;
  int   cmds_sent = 0;
  int   rsps_checked = 0;
  int   full_rejects = 0;
  int   empty_rejects = 0;
  int   peak_count = 0;

  dir_row_t dir_rows [25];

  double_ended_queue_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // applies one command to the queue model and returns its answer
  function automatic rsp_t apply_cmd(input cmd_t c);
    rsp_t r;
    logic [IDX_W-1:0] slot;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          r.status = ST_FULL;
        end else if (c.opcode == OP_PUSH_FRONT) begin
          ring_head = ring_head - 1'b1;
          ring[ring_head] = c.push_value;
          ring_count = ring_count + 1'b1;
        end else begin
          slot = ring_head + ring_count[IDX_W-1:0];
          ring[slot] = c.push_value;
          ring_count = ring_count + 1'b1;
        end
      end
      OP_POP_FRONT, OP_FRONT: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_VALUE;
          r.data_value = ring[ring_head];
          if (c.opcode == OP_POP_FRONT) begin
            ring_head = ring_head + 1'b1;
            ring_count = ring_count - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_BACK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = ring_head + ring_count[IDX_W-1:0] - 1'b1;
          r.status = ST_VALUE;
          r.data_value = ring[slot];
          if (c.opcode == OP_POP_BACK) ring_count = ring_count - 1'b1;
        end
      end
      OP_SIZE: r.status = ST_SIZE;
      OP_CLEAR, OP_EXIT: begin
        ring_head = '0;
        ring_count = '0;
        r.status = (c.opcode == OP_EXIT) ? ST_BYE : ST_OK;
      end
      default: ;
    endcase
    r.element_count = ring_count;
    return r;
  endfunction

  // command side predicts, result side checks against the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        want = apply_cmd(cmd);
        if (use_typed) want = typed_rsp;
        expected_rsps = {expected_rsps, want};
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got status=%0d data=%0d count=%0d",
                   $time, rsp.status, rsp.data_value, rsp.element_count);
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          rsps_checked++;
          if (want.status == ST_FULL) full_rejects++;
          if (want.status == ST_EMPTY) empty_rejects++;
          if (int'(want.element_count) > peak_count) peak_count = want.element_count;
          if (rsp.status !== want.status || rsp.data_value !== want.data_value ||
              rsp.element_count !== want.element_count) begin
            fail_count++;
            $display("%0t: mismatch expected status=%0d data=%0d count=%0d,", $time,
                     want.status, want.data_value, want.element_count);
            $display("    got status=%0d data=%0d count=%0d",
                     rsp.status, rsp.data_value, rsp.element_count);
          end
        end
      end
    end
  end

  // receiver: random stalls, with a long hold-off whenever one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (burst_req != burst_done) begin
        burst_done = burst_req;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // offers one command and returns at the edge where it transfers
  task automatic send(input cmd_t c, input bit typed_in, input rsp_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    use_typed <= typed_in;
    typed_rsp <= want;
    do @(posedge clk); while (cmd_stall);
    cmds_sent++;
  endtask

  function automatic logic [3:0] pick_op(input load_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 48) return OP_PUSH_FRONT;
        if (r < 95) return OP_PUSH_BACK;
        if (r < 97) return OP_POP_FRONT;
        if (r < 98) return OP_FRONT;
        if (r < 99) return OP_SIZE;
        return OP_BACK;
      end
      MODE_DRAIN: begin
        if (r < 35) return OP_POP_FRONT;
        if (r < 70) return OP_POP_BACK;
        if (r < 80) return OP_FRONT;
        if (r < 88) return OP_BACK;
        if (r < 93) return OP_SIZE;
        if (r < 96) return OP_PUSH_FRONT;
        return OP_PUSH_BACK;
      end
      default: begin
        if (r < 17) return OP_PUSH_FRONT;
        if (r < 34) return OP_PUSH_BACK;
        if (r < 48) return OP_POP_FRONT;
        if (r < 62) return OP_POP_BACK;
        if (r < 70) return OP_FRONT;
        if (r < 78) return OP_BACK;
        if (r < 85) return OP_SIZE;
        if (r < 88) return OP_CLEAR;
        if (r < 90) return OP_EXIT;
        if (r < 93) return 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        return OP_PUSH_BACK;
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cmd_t       c;
    rsp_t       want;
    load_mode_t mode;

    // empty-queue errors, both ends with extreme values, wrap below slot zero,
    // ignored opcodes, clear and exit followed by normal use
    dir_rows = '{
      '{OP_FRONT,        32'h0,          1'b1, ST_EMPTY, 32'h0,          11'd0},
      '{OP_BACK,         32'h0,          1'b1, ST_EMPTY, 32'h0,          11'd0},
      '{OP_POP_FRONT,    32'h0,          1'b1, ST_EMPTY, 32'h0,          11'd0},
      '{OP_POP_BACK,     32'h0,          1'b1, ST_EMPTY, 32'h0,          11'd0},
      '{OP_SIZE,         32'h0,          1'b1, ST_SIZE,  32'h0,          11'd0},
      '{OP_PUSH_BACK,    32'h7fff_ffff,  1'b1, ST_OK,    32'h0,          11'd1},
      '{OP_PUSH_FRONT,   32'h8000_0000,  1'b1, ST_OK,    32'h0,          11'd2},
      '{OP_FRONT,        32'h0,          1'b1, ST_VALUE, 32'h8000_0000,  11'd2},
      '{OP_BACK,         32'h0,          1'b1, ST_VALUE, 32'h7fff_ffff,  11'd2},
      '{OP_PUSH_BACK,    32'hffff_ffff,  1'b1, ST_OK,    32'h0,          11'd3},
      '{OP_SIZE,         32'h0,          1'b1, ST_SIZE,  32'h0,          11'd3},
      '{OP_POP_BACK,     32'h0,          1'b1, ST_VALUE, 32'hffff_ffff,  11'd2},
      '{OP_POP_FRONT,    32'h0,          1'b1, ST_VALUE, 32'h8000_0000,  11'd1},
      '{OP_POP_FRONT,    32'h0,          1'b1, ST_VALUE, 32'h7fff_ffff,  11'd0},
      '{OP_POP_BACK,     32'h0,          1'b1, ST_EMPTY, 32'h0,          11'd0},
      '{OP_PUSH_FRONT,   32'h0,          1'b1, ST_OK,    32'h0,          11'd1},
      '{OP_LAST_UNUSED,  32'hffff_ffff,  1'b1, ST_OK,    32'h0,          11'd1},
      '{OP_FIRST_UNUSED, 32'h5555_aaaa,  1'b1, ST_OK,    32'h0,          11'd1},
      '{OP_CLEAR,        32'h0,          1'b1, ST_OK,    32'h0,          11'd0},
      '{OP_FRONT,        32'h0,          1'b1, ST_EMPTY, 32'h0,          11'd0},
      '{OP_PUSH_BACK,    32'h1234_5678,  1'b1, ST_OK,    32'h0,          11'd1},
      '{OP_EXIT,         32'h0,          1'b1, ST_BYE,   32'h0,          11'd0},
      '{OP_PUSH_FRONT,   32'h5a5a_5a5a,  1'b0, ST_OK,    32'h0,          11'd0},
      '{OP_BACK,         32'h0,          1'b0, ST_OK,    32'h0,          11'd0},
      '{OP_CLEAR,        32'h0,          1'b1, ST_OK,    32'h0,          11'd0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 17;
    stall_pct    = 63;
    foreach (dir_rows[i]) begin
      c.opcode     = dir_rows[i].op;
      c.push_value = dir_rows[i].value;
      want.status        = dir_rows[i].st;
      want.data_value    = dir_rows[i].dv;
      want.element_count = dir_rows[i].n;
      send(c, dir_rows[i].typed, want);
    end

    // mixed traffic, then a long fill through full, a partial drain, mixed again
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 0) begin
        send_gap_pct = 17;
        stall_pct    = 63;
        burst_req++;
      end else if (i == RANDOM_ITEMS / 3) begin
        send_gap_pct = 63;
        stall_pct    = 17;
        burst_req++;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct = 0;
        stall_pct    = 0;
        burst_req++;
      end
      if (i < 200) mode = MODE_MIX;
      else if (i < 1400) mode = MODE_FILL;
      else if (i < 1750) mode = MODE_DRAIN;
      else mode = MODE_MIX;
      c.opcode     = pick_op(mode);
      c.push_value = rand_value();
      send(c, 1'b0, '0);
    end
    cmd_valid <= 1'b0;
    stall_pct = 0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d commands, %0d results checked, peak occupancy %0d of %0d",
             cmds_sent, rsps_checked, peak_count, DEPTH);
    $display("tb: %0d full rejections, %0d empty rejections, %0d mismatches",
             full_rejects, empty_rejects, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
